### hw/rtl/msp_pkg.sv
// shared types and constants for the msp v1 response parser
// no dependencies; imported by the parser top level and its checker
package msp_pkg;

    // frame delimiter and direction characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
    localparam logic [7:0] CH_RESP   = 8'h3E;  // '>'
    localparam logic [7:0] CH_ERR    = 8'h21;  // '!'

    localparam logic [15:0] MAX_BYTES_RST = 16'd1024;

    // configuration register indexes
    localparam logic CFG_EXPECTED_CMD = 1'b0;
    localparam logic CFG_MAX_BYTES    = 1'b1;

    // result status codes
    localparam logic [2:0] ST_PROGRESS = 3'd0;
    localparam logic [2:0] ST_PAYLOAD  = 3'd1;
    localparam logic [2:0] ST_OK       = 3'd2;
    localparam logic [2:0] ST_SKIP     = 3'd3;
    localparam logic [2:0] ST_ERRFRAME = 3'd4;
    localparam logic [2:0] ST_BADSUM   = 3'd5;
    localparam logic [2:0] ST_LIMIT    = 3'd6;
    localparam logic [2:0] ST_IGNORED  = 3'd7;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       begin_req;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_cmd;
        logic [7:0] frame_size;
        logic [7:0] computed_checksum;
        logic       last;
    } t_out;

endpackage

### hw/rtl/msp_v1_response_parser.sv
// msp v1 response frame parser: byte state machine with a two-entry result buffer
// depends on msp_pkg
// an accepted byte's result is registered in the main result register, or in the skid entry while that one is held
// one byte per cycle while o_in_stall is low; the parser state is updated at the accepting edge
// o_in_stall rises only when both result registers hold untaken transactions
// reset: synchronous active-low, clears parser and byte count, sets config to its reset values, empties buffers
module msp_v1_response_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_wdata,
    // byte input channel
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  msp_pkg::t_in  i_in,
    // result channel
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output msp_pkg::t_out o_out
);
    import msp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_M     = 3'd1,
        PH_DIR   = 3'd2,
        PH_SIZE  = 3'd3,
        PH_CMD   = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    // configuration
    logic [7:0]  r_expected_cmd;
    logic [15:0] r_max_bytes;

    // parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_size, n_size;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_pcount, n_pcount;
    logic [15:0] r_consumed, n_consumed;
    logic        r_finished, n_finished;

    // result buffer: main register plus skid entry
    logic        r_out_valid;
    t_out        r_out;
    logic        r_skid_valid;
    t_out        r_skid;
    t_out        n_res;

    logic        w_accept;
    logic        w_take;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && !i_out_stall;

    // next parser state and result for the byte on the input
    always_comb begin
        logic       ended;
        logic       skipped;
        logic [7:0] b;
        b       = i_in.rx_byte;
        ended   = 1'b0;
        skipped = 1'b0;

        // begin request clears everything before this byte is handled
        n_phase    = i_in.begin_req ? PH_HUNT : r_phase;
        n_size     = i_in.begin_req ? 8'd0    : r_size;
        n_cmd      = i_in.begin_req ? 8'd0    : r_cmd;
        n_xor      = i_in.begin_req ? 8'd0    : r_xor;
        n_pcount   = i_in.begin_req ? 8'd0    : r_pcount;
        n_consumed = i_in.begin_req ? 16'd0   : r_consumed;
        n_finished = i_in.begin_req ? 1'b0    : r_finished;

        n_res               = '0;
        n_res.status        = ST_PROGRESS;

        if (n_finished) begin
            // transaction over: byte is ignored, no state change
            n_res.status = ST_IGNORED;
        end else begin
            // saturating byte count
            if (n_consumed != 16'hFFFF) begin
                n_consumed = n_consumed + 16'd1;
            end
            unique case (n_phase)
                PH_M: begin
                    n_phase = (b == CH_M) ? PH_DIR : PH_HUNT;
                end
                PH_DIR: begin
                    if (b == CH_RESP) begin
                        n_phase = PH_SIZE;
                    end else if (b == CH_ERR) begin
                        n_res.status = ST_ERRFRAME;
                        ended        = 1'b1;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_SIZE: begin
                    n_size  = b;
                    n_xor   = b;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    n_cmd    = b;
                    n_xor    = n_xor ^ b;
                    n_pcount = 8'd0;
                    n_phase  = (n_size == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    n_res.status        = ST_PAYLOAD;
                    n_res.payload_byte  = b;
                    n_res.payload_index = n_pcount;
                    n_xor               = n_xor ^ b;
                    n_pcount            = n_pcount + 8'd1;
                    if (n_pcount == n_size) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (b != n_xor) begin
                        n_res.status = ST_BADSUM;
                        ended        = 1'b1;
                    end else if (n_cmd != r_expected_cmd) begin
                        n_res.status = ST_SKIP;
                        skipped      = 1'b1;
                    end else begin
                        n_res.status = ST_OK;
                        ended        = 1'b1;
                    end
                end
                default: begin
                    // hunting for the dollar sign
                    if (b == CH_DOLLAR) begin
                        n_phase = PH_M;
                    end
                end
            endcase
            // byte limit, unless this byte already closed the transaction
            if (!ended && (n_consumed >= r_max_bytes)) begin
                n_res.status        = ST_LIMIT;
                n_res.payload_byte  = 8'd0;
                n_res.payload_index = 8'd0;
                ended               = 1'b1;
            end
        end

        // frame fields show the registers after this byte, before a skip clears them
        n_res.frame_cmd         = n_cmd;
        n_res.frame_size        = n_size;
        n_res.computed_checksum = n_xor;
        n_res.last              = ended;

        if (ended) begin
            n_finished = 1'b1;
        end else if (skipped) begin
            // other command: keep its code, go back to the hunt
            n_phase  = PH_HUNT;
            n_size   = 8'd0;
            n_xor    = 8'd0;
            n_pcount = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_cmd <= 8'd0;
            r_max_bytes    <= MAX_BYTES_RST;
            r_phase        <= PH_HUNT;
            r_size         <= 8'd0;
            r_cmd          <= 8'd0;
            r_xor          <= 8'd0;
            r_pcount       <= 8'd0;
            r_consumed     <= 16'd0;
            r_finished     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXPECTED_CMD: r_expected_cmd <= i_cfg_wdata[7:0];
                    CFG_MAX_BYTES:    r_max_bytes    <= i_cfg_wdata;
                    default:          r_max_bytes    <= r_max_bytes;
                endcase
            end

            // parser state advances on every accepted byte
            if (w_accept) begin
                r_phase    <= n_phase;
                r_size     <= n_size;
                r_cmd      <= n_cmd;
                r_xor      <= n_xor;
                r_pcount   <= n_pcount;
                r_consumed <= n_consumed;
                r_finished <= n_finished;
            end

            // result buffer
            if (!r_out_valid || w_take) begin
                if (r_skid_valid) begin
                    // skid entry moves up; no byte is accepted this cycle
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (w_accept) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_accept) begin
                // main register held by a stall: park the new result
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

### hw/rtl/msp_checker.sv
// port-level checks for the msp v1 response parser, attached by bind
// depends on msp_pkg and msp_v1_response_parser
module msp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input msp_pkg::t_out o_out
);
    import msp_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    // last only on the four ending codes
    a_last_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |->
            (o_out.status == ST_OK || o_out.status == ST_ERRFRAME ||
             o_out.status == ST_BADSUM || o_out.status == ST_LIMIT))
        else $error("last on a non-ending status");

    // payload fields are zero unless a payload byte is shown
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_PAYLOAD) |->
            (o_out.payload_byte == 8'd0 && o_out.payload_index == 8'd0))
        else $error("payload fields set on a non-payload status");

    // input stall only while a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty result register");

    // reset empties the result channel
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("result channel not empty after reset");

endmodule

bind msp_v1_response_parser msp_checker u_msp_checker (.*);

### tb/tb_msp_v1_response_parser.sv
// self-checking bench for the msp v1 response parser: byte stream in, one status per byte out
// depends on msp_pkg and msp_v1_response_parser; predicts every result from its own parser copy
// stimulus is a short directed run, then random frame sequences under three idling regimes
module tb_msp_v1_response_parser;
    import msp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // parser phases, as the predictor tracks them
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_M     = 3'd1,
        PH_DIR   = 3'd2,
        PH_SIZE  = 3'd3,
        PH_CMD   = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = CFG_EXPECTED_CMD;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in         i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;

    msp_v1_response_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    // bytes waiting to be sent, and parse results still owed by the block
    t_in  rx_backlog[$];
    t_out parse_results_due[$];

    int   send_idle_pct  = 37;
    int   recv_stall_pct = 75;
    int   mismatches     = 0;
    int   cycles         = 0;
    int   bytes_queued   = 0;
    logic begin_next     = 1'b0;

    // register copies, at their reset values
    logic [7:0]  want_cmd   = 8'd0;
    logic [15:0] byte_limit = MAX_BYTES_RST;

    // predictor state, at its reset values
    t_phase      scan_phase  = PH_HUNT;
    logic [7:0]  frame_len   = '0;
    logic [7:0]  frame_code  = '0;
    logic [7:0]  run_xor     = '0;
    logic [7:0]  data_seen   = '0;
    logic [15:0] bytes_taken = '0;
    logic        txn_over    = 1'b0;

    // work out the result for one accepted byte and advance the parser copy
    function automatic t_out predict_parse_result(t_in item);
        t_out        res;
        logic        ended;
        logic        skipped;
        logic [7:0]  b;
        logic [15:0] lim;
        res     = '0;
        ended   = 1'b0;
        skipped = 1'b0;
        b       = item.rx_byte;
        lim     = (byte_limit == 16'd0) ? 16'd1 : byte_limit;
        res.status = ST_PROGRESS;

        // begin wipes the parser and the byte count before this byte
        if (item.begin_req) begin
            scan_phase  = PH_HUNT;
            frame_len   = '0;
            frame_code  = '0;
            run_xor     = '0;
            data_seen   = '0;
            bytes_taken = '0;
            txn_over    = 1'b0;
        end

        if (txn_over) begin
            // transaction already over: nothing counted, nothing changes
            res.status = ST_IGNORED;
        end else begin
            if (bytes_taken != 16'hFFFF)
                bytes_taken = bytes_taken + 16'd1;
            case (scan_phase)
                PH_M: begin
                    scan_phase = (b == CH_M) ? PH_DIR : PH_HUNT;
                end
                PH_DIR: begin
                    if (b == CH_RESP) begin
                        scan_phase = PH_SIZE;
                    end else if (b == CH_ERR) begin
                        res.status = ST_ERRFRAME;
                        ended      = 1'b1;
                    end else begin
                        // bad direction byte, back to the hunt without a rescan
                        scan_phase = PH_HUNT;
                    end
                end
                PH_SIZE: begin
                    frame_len  = b;
                    run_xor    = b;
                    scan_phase = PH_CMD;
                end
                PH_CMD: begin
                    frame_code = b;
                    run_xor    = run_xor ^ b;
                    data_seen  = '0;
                    scan_phase = (frame_len == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    res.status        = ST_PAYLOAD;
                    res.payload_byte  = b;
                    res.payload_index = data_seen;
                    run_xor           = run_xor ^ b;
                    data_seen         = data_seen + 8'd1;
                    if (data_seen == frame_len)
                        scan_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    if (b != run_xor) begin
                        res.status = ST_BADSUM;
                        ended      = 1'b1;
                    end else if (frame_code != want_cmd) begin
                        res.status = ST_SKIP;
                        skipped    = 1'b1;
                    end else begin
                        res.status = ST_OK;
                        ended      = 1'b1;
                    end
                end
                default: begin
                    if (b == CH_DOLLAR)
                        scan_phase = PH_M;
                end
            endcase
            // a byte that already ended the transaction outranks the limit
            if (!ended && bytes_taken >= lim) begin
                res.status        = ST_LIMIT;
                res.payload_byte  = '0;
                res.payload_index = '0;
                ended             = 1'b1;
            end
        end

        res.frame_cmd         = frame_code;
        res.frame_size        = frame_len;
        res.computed_checksum = run_xor;
        res.last              = ended;

        if (ended) begin
            txn_over = 1'b1;
        end else if (skipped) begin
            // skipped frame keeps its command code, the rest starts over
            scan_phase = PH_HUNT;
            frame_len  = '0;
            run_xor    = '0;
            data_seen  = '0;
        end
        return res;
    endfunction

    // byte driver: holds a stalled transaction, otherwise sends or idles at random
    always @(posedge i_clk) begin : drive_bytes
        logic taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                parse_results_due.insert(parse_results_due.size(),
                                         predict_parse_result(i_in));
                void'(rx_backlog.pop_front());
            end
            if (i_in_valid && !taken) begin
                // stalled: payload and valid stay as they are
            end else if (rx_backlog.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in       <= rx_backlog[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // result monitor: every accepted result against the oldest prediction
    always @(posedge i_clk) begin : watch_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (parse_results_due.size() == 0) begin
                $error("result transaction with no byte outstanding");
                mismatches++;
            end else begin
                want = parse_results_due.pop_front();
                check_field("status", 8'(want.status), 8'(o_out.status));
                check_field("payload_byte", want.payload_byte, o_out.payload_byte);
                check_field("payload_index", want.payload_index, o_out.payload_index);
                check_field("frame_cmd", want.frame_cmd, o_out.frame_cmd);
                check_field("frame_size", want.frame_size, o_out.frame_size);
                check_field("computed_checksum", want.computed_checksum,
                            o_out.computed_checksum);
                check_field("last", 8'(want.last), 8'(o_out.last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // queue one byte; the begin flag goes on the first byte after it is armed
    function automatic void push_rx(logic [7:0] b);
        t_in item;
        item.rx_byte   = b;
        item.begin_req = begin_next;
        begin_next     = 1'b0;
        rx_backlog.insert(rx_backlog.size(), item);
        bytes_queued++;
    endfunction

    // whole response frame, optionally with a corrupted checksum
    function automatic void push_frame(logic [7:0] cmd, logic [7:0] len, bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        push_rx(CH_RESP);
        push_rx(len);
        push_rx(cmd);
        sum = len ^ cmd;
        for (int i = 0; i < len; i++) begin
            d = 8'($urandom);
            push_rx(d);
            sum = sum ^ d;
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_rx(sum);
    endfunction

    // mostly short payloads, now and then the longest one
    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 99) < 2) ? 8'd255 : 8'($urandom_range(0, 12));
    endfunction

    // one transaction: junk and broken headers, frames for other commands, then mostly an ending
    function automatic void push_transaction();
        int n;
        begin_next = ($urandom_range(0, 9) != 0);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    push_rx(CH_DOLLAR);
                    push_rx(8'($urandom));
                end
                1: begin
                    push_rx(CH_DOLLAR);
                    push_rx(CH_M);
                    push_rx(8'($urandom));
                end
                default: push_rx(8'($urandom));
            endcase
        end
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            push_frame(want_cmd ^ 8'($urandom_range(1, 255)), pick_len(),
                       $urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
            7: begin
                push_rx(CH_DOLLAR);
                push_rx(CH_M);
                push_rx(CH_ERR);
            end
            8: push_frame(want_cmd, pick_len(), 1'b1);
            9: ;
            default: push_frame(want_cmd, pick_len(), 1'b0);
        endcase
        // trailing bytes, usually ignored once the transaction is over
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            push_rx(8'($urandom));
    endfunction

    task automatic write_reg(logic idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_EXPECTED_CMD)
            want_cmd = data[7:0];
        else
            byte_limit = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every byte is sent and every result has come back
    task automatic settle();
        while (rx_backlog.size() != 0 || i_in_valid || parse_results_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic random_config();
        case ($urandom_range(0, 3))
            0: write_reg(CFG_EXPECTED_CMD, 16'd0);
            1: write_reg(CFG_EXPECTED_CMD, 16'd255);
            default: write_reg(CFG_EXPECTED_CMD, 16'($urandom_range(0, 255)));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(CFG_MAX_BYTES, 16'd1);
            1: write_reg(CFG_MAX_BYTES, 16'd65535);
            2: write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);
            3, 4: write_reg(CFG_MAX_BYTES, 16'($urandom_range(2, 40)));
            default: write_reg(CFG_MAX_BYTES, 16'($urandom_range(41, 700)));
        endcase
    endtask

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_EXPECTED_CMD, 16'd0);
        write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);

        // active straight out of reset: empty frame for command 0, then an ignored byte
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        push_rx(CH_RESP);
        push_rx(8'h00);
        push_rx(8'h00);
        push_rx(8'h00);
        push_rx(8'hFF);
        // error direction
        begin_next = 1'b1;
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        push_rx(CH_ERR);
        // header mismatches, a skipped frame, then a bad checksum
        begin_next = 1'b1;
        push_rx(CH_DOLLAR);
        push_rx(8'h5A);
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        push_rx(8'h41);
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        push_rx(CH_RESP);
        push_rx(8'h01);
        push_rx(8'h07);
        push_rx(8'hFF);
        push_rx(8'h01 ^ 8'h07 ^ 8'hFF);
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        push_rx(CH_RESP);
        push_rx(8'h00);
        push_rx(8'h00);
        push_rx(8'h01);
        settle();

        // smallest limit on the first byte
        write_reg(CFG_MAX_BYTES, 16'd1);
        begin_next = 1'b1;
        push_rx(CH_DOLLAR);
        settle();

        // done ok on the very byte that reaches the limit wins over the limit
        write_reg(CFG_EXPECTED_CMD, 16'd255);
        write_reg(CFG_MAX_BYTES, 16'd6);
        begin_next = 1'b1;
        push_frame(8'hFF, 8'd0, 1'b0);
        settle();

        // limit lowered below the running count: the next byte stops the transaction
        write_reg(CFG_MAX_BYTES, 16'd65535);
        begin_next = 1'b1;
        push_rx(CH_DOLLAR);
        push_rx(CH_M);
        settle();
        write_reg(CFG_MAX_BYTES, 16'd1);
        push_rx(CH_RESP);
        settle();

        // random part: receiver-heavy stalling, sender-heavy idling, then flat out
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct  = (mode == 0) ? 37 : (mode == 1) ? 75 : 0;
            recv_stall_pct = (mode == 0) ? 75 : (mode == 1) ? 37 : 0;
            settle();
            random_config();
            target = bytes_queued + 340;
            while (bytes_queued < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    settle();
                    random_config();
                end
                push_transaction();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_v1_response_parser.sv
hw/rtl/msp_checker.sv
tb/tb_msp_v1_response_parser.sv
